// ===== sv/scft_pkg.sv =====
package scft_pkg;

    localparam int DEF_ENTRIES = 16;
    localparam int MAX_RESULTS = 16;
    localparam int FOUND_W     = $clog2(MAX_RESULTS + 1);

    localparam int KIND_W   = 3;
    localparam int DRIVE_W  = 8;
    localparam int SECTOR_W = 32;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;
    localparam int REQ_W    = 2;
    localparam int TAG_W    = DRIVE_W + SECTOR_W;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_CACHED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE      = 2'd2;

    localparam logic [REQ_W-1:0] REQ_NONE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WBACK = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FILL  = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        K_OPEN     = 3'd0,
        K_READ     = 3'd1,
        K_WRITE    = 3'd2,
        K_FLUSH1   = 3'd3,
        K_FLUSHALL = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_VICT_RD,
        S_VICT,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic                hit;
        logic [REQ_W-1:0]    request;
        logic [DRIVE_W-1:0]  req_drive;
        logic [SECTOR_W-1:0] req_sector;
        logic                last;
    } t_result;

    function automatic t_result mk_res(
        input logic [STATUS_W-1:0] status,
        input logic [SLOT_W-1:0]   slot,
        input logic                hit,
        input logic [REQ_W-1:0]    request,
        input logic [DRIVE_W-1:0]  req_drive,
        input logic [SECTOR_W-1:0] req_sector,
        input logic                last
    );
        t_result r;
        r.status     = status;
        r.slot       = slot;
        r.hit        = hit;
        r.request    = request;
        r.req_drive  = req_drive;
        r.req_sector = req_sector;
        r.last       = last;
        return r;
    endfunction

endpackage

// ===== sv/sector_cache_fifo_tags.sv =====
// Tag and replacement engine of a fully associative disk sector cache with
// round-robin (FIFO) eviction. A command is taken when start is high and busy
// is low; its results come out one per strobe on o_valid, each shown for one
// cycle only, and o_last marks the final one. The receiver cannot stall: every
// strobed result must be captured. Tags live in one RAM with a registered read
// port and the lookup walks it one entry per cycle. Flush all walks the occupied
// slots oldest first, one per cycle; at most 16 write-backs are given per
// command. Other kinds give no result. sector_limit is written through the cfg
// channel, which is ready whenever busy is low.
module sector_cache_fifo_tags #(
    parameter int ENTRIES = scft_pkg::DEF_ENTRIES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [scft_pkg::KIND_W-1:0]    i_kind,
    input  logic [scft_pkg::DRIVE_W-1:0]   i_drive,
    input  logic [scft_pkg::SECTOR_W-1:0]  i_sector,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [scft_pkg::SECTOR_W-1:0]  i_cfg_data,
    output logic                           o_valid,
    output logic [scft_pkg::STATUS_W-1:0]  o_status,
    output logic [scft_pkg::SLOT_W-1:0]    o_slot,
    output logic                           o_hit,
    output logic [scft_pkg::REQ_W-1:0]     o_request,
    output logic [scft_pkg::DRIVE_W-1:0]   o_req_drive,
    output logic [scft_pkg::SECTOR_W-1:0]  o_req_sector,
    output logic                           o_last
);

    import scft_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0]   ENT_CNT  = CNT_W'(ENTRIES);
    localparam logic [FOUND_W-1:0] MAX_RES  = FOUND_W'(MAX_RESULTS);

    t_state                r_state, n_state;
    t_kind                 r_kind, n_kind;
    logic [DRIVE_W-1:0]    r_drive, n_drive;
    logic [SECTOR_W-1:0]   r_sector, n_sector;
    logic [SECTOR_W-1:0]   r_limit, n_limit;
    logic [ENTRIES-1:0]    r_valid, n_valid;
    logic [ENTRIES-1:0]    r_filled, n_filled;
    logic [ENTRIES-1:0]    r_dirty, n_dirty;
    logic [CNT_W-1:0]      r_used, n_used;
    logic [IDX_W-1:0]      r_oldest, n_oldest;
    logic [CNT_W-1:0]      r_idx, n_idx;
    logic                  r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0]      r_cmp_idx, n_cmp_idx;
    logic [IDX_W-1:0]      r_j, n_j;
    logic [FOUND_W-1:0]    r_found, n_found;
    logic                  r_pend_vld, n_pend_vld;
    t_result               r_pend, n_pend;
    logic                  r_res_valid, n_res_valid;
    t_result               r_res, n_res;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [TAG_W-1:0]      ram_wdata;
    logic [IDX_W-1:0]      ram_raddr;
    logic [TAG_W-1:0]      ram_rdata;
    logic [DRIVE_W-1:0]    rd_drive;
    logic [SECTOR_W-1:0]   rd_sector;

    logic                  cfg_we;
    logic                  look_issue;
    logic [IDX_W-1:0]      look_addr;
    logic                  match;
    logic                  flush_issue;
    logic                  flush_hit;
    logic [IDX_W-1:0]      j_next;
    logic [IDX_W-1:0]      oldest_next;
    logic [IDX_W-1:0]      alloc_idx;

    scft_ram #(
        .WIDTH (TAG_W),
        .DEPTH (ENTRIES),
        .AW    (IDX_W)
    ) u_tags (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_drive    = ram_rdata[SECTOR_W +: DRIVE_W];
    assign rd_sector   = ram_rdata[SECTOR_W-1:0];
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = !busy;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign look_issue  = (r_idx < ENT_CNT);
    assign look_addr   = look_issue ? r_idx[IDX_W-1:0] : '0;
    assign match       = r_valid[r_cmp_idx] && (ram_rdata == {r_drive, r_sector});
    assign flush_issue = (r_idx < r_used) && (r_found < MAX_RES);
    assign flush_hit   = r_valid[r_j] && r_dirty[r_j];
    assign j_next      = (r_j == LAST_IDX) ? '0 : r_j + 1'b1;
    assign oldest_next = (r_oldest == LAST_IDX) ? '0 : r_oldest + 1'b1;
    assign alloc_idx   = look_issue ? '0 : r_used[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= '1;
            r_valid     <= '0;
            r_filled    <= '0;
            r_dirty     <= '0;
            r_used      <= '0;
            r_oldest    <= '0;
            r_idx       <= '0;
            r_cmp_vld   <= 1'b0;
            r_found     <= '0;
            r_pend_vld  <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_limit     <= n_limit;
            r_valid     <= n_valid;
            r_filled    <= n_filled;
            r_dirty     <= n_dirty;
            r_used      <= n_used;
            r_oldest    <= n_oldest;
            r_idx       <= n_idx;
            r_cmp_vld   <= n_cmp_vld;
            r_found     <= n_found;
            r_pend_vld  <= n_pend_vld;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_drive   <= n_drive;
        r_sector  <= n_sector;
        r_cmp_idx <= n_cmp_idx;
        r_j       <= n_j;
        r_pend    <= n_pend;
        r_res     <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_drive     = r_drive;
        n_sector    = r_sector;
        n_limit     = r_limit;
        n_valid     = r_valid;
        n_filled    = r_filled;
        n_dirty     = r_dirty;
        n_used      = r_used;
        n_oldest    = r_oldest;
        n_idx       = r_idx;
        n_cmp_vld   = 1'b0;
        n_cmp_idx   = r_cmp_idx;
        n_j         = r_j;
        n_found     = r_found;
        n_pend_vld  = r_pend_vld;
        n_pend      = r_pend;
        n_res_valid = 1'b0;
        n_res       = r_res;
        ram_we      = 1'b0;
        ram_waddr   = alloc_idx;
        ram_wdata   = {r_drive, r_sector};
        ram_raddr   = '0;

        if (cfg_we) begin
            n_limit = i_cfg_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_kind     = t_kind'(i_kind);
                    n_drive    = i_drive;
                    n_sector   = i_sector;
                    n_idx      = '0;
                    n_found    = '0;
                    n_pend_vld = 1'b0;
                    n_j        = r_oldest;
                    unique case (i_kind) inside
                        K_OPEN, K_READ, K_WRITE, K_FLUSH1: n_state = S_LOOK;
                        K_FLUSHALL:                        n_state = S_FLUSH;
                        default:                           n_state = S_IDLE;
                    endcase
                end
            end

            S_LOOK: begin
                ram_raddr = look_addr;
                n_cmp_vld = look_issue;
                n_cmp_idx = look_addr;
                if (look_issue) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_cmp_vld && match) begin
                    n_state     = S_IDLE;
                    n_res_valid = 1'b1;
                    n_res = mk_res(ST_OK, SLOT_W'(r_cmp_idx), 1'b1, REQ_NONE, '0, '0, 1'b1);
                    unique case (r_kind)
                        K_READ: begin
                            if (!r_filled[r_cmp_idx]) begin
                                n_filled[r_cmp_idx] = 1'b1;
                                n_res = mk_res(ST_OK, SLOT_W'(r_cmp_idx), 1'b0, REQ_FILL,
                                               r_drive, r_sector, 1'b1);
                            end
                        end
                        K_WRITE: begin
                            n_dirty[r_cmp_idx]  = 1'b1;
                            n_filled[r_cmp_idx] = 1'b1;
                        end
                        K_FLUSH1: begin
                            if (r_dirty[r_cmp_idx]) begin
                                n_dirty[r_cmp_idx] = 1'b0;
                                n_res = mk_res(ST_OK, SLOT_W'(r_cmp_idx), 1'b1, REQ_WBACK,
                                               r_drive, r_sector, 1'b1);
                            end
                        end
                        default: ;
                    endcase
                end else if (r_cmp_vld && (r_cmp_idx == LAST_IDX)) begin
                    n_state     = S_IDLE;
                    n_res_valid = 1'b1;
                    if (r_kind != K_OPEN) begin
                        n_res = mk_res(ST_NOT_CACHED, '0, 1'b0, REQ_NONE, '0, '0, 1'b1);
                    end else if (r_sector >= r_limit) begin
                        n_res = mk_res(ST_RANGE, '0, 1'b0, REQ_NONE, '0, '0, 1'b1);
                    end else if (r_used < ENT_CNT) begin
                        ram_we              = 1'b1;
                        n_used              = r_used + 1'b1;
                        n_valid[alloc_idx]  = 1'b1;
                        n_filled[alloc_idx] = 1'b0;
                        n_dirty[alloc_idx]  = 1'b0;
                        n_res = mk_res(ST_OK, SLOT_W'(alloc_idx), 1'b0, REQ_NONE,
                                       '0, '0, 1'b1);
                    end else begin
                        n_res_valid = 1'b0;
                        n_state     = S_VICT_RD;
                    end
                end
            end

            S_VICT_RD: begin
                ram_raddr = r_oldest;
                n_state   = S_VICT;
            end

            S_VICT: begin
                ram_we             = 1'b1;
                ram_waddr          = r_oldest;
                n_valid[r_oldest]  = 1'b1;
                n_filled[r_oldest] = 1'b0;
                n_dirty[r_oldest]  = 1'b0;
                n_oldest           = oldest_next;
                n_state            = S_IDLE;
                n_res_valid        = 1'b1;
                if (r_valid[r_oldest] && r_dirty[r_oldest]) begin
                    n_res = mk_res(ST_OK, SLOT_W'(r_oldest), 1'b0, REQ_WBACK,
                                   rd_drive, rd_sector, 1'b1);
                end else begin
                    n_res = mk_res(ST_OK, SLOT_W'(r_oldest), 1'b0, REQ_NONE,
                                   '0, '0, 1'b1);
                end
            end

            S_FLUSH: begin
                ram_raddr = r_j;
                n_cmp_idx = r_j;
                if (flush_issue) begin
                    n_idx     = r_idx + 1'b1;
                    n_j       = j_next;
                    n_cmp_vld = flush_hit;
                    if (flush_hit) begin
                        n_dirty[r_j] = 1'b0;
                        n_found      = r_found + 1'b1;
                    end
                end
                if (r_cmp_vld) begin
                    // hold the newest write-back until the next one proves it is not last
                    if (r_pend_vld) begin
                        n_res_valid = 1'b1;
                        n_res       = r_pend;
                    end
                    n_pend_vld = 1'b1;
                    n_pend = mk_res(ST_OK, SLOT_W'(r_cmp_idx), 1'b0, REQ_WBACK,
                                    rd_drive, rd_sector, 1'b0);
                end else if (!flush_issue) begin
                    n_state     = S_IDLE;
                    n_res_valid = 1'b1;
                    n_pend_vld  = 1'b0;
                    if (r_pend_vld) begin
                        n_res      = r_pend;
                        n_res.last = 1'b1;
                    end else begin
                        n_res = mk_res(ST_OK, '0, 1'b0, REQ_NONE, '0, '0, 1'b1);
                    end
                end
            end
        endcase
    end

    assign o_valid      = r_res_valid;
    assign o_status     = r_res.status;
    assign o_slot       = r_res.slot;
    assign o_hit        = r_res.hit;
    assign o_request    = r_res.request;
    assign o_req_drive  = r_res.req_drive;
    assign o_req_sector = r_res.req_sector;
    assign o_last       = r_res.last;

    a_last_ends_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == !busy))
        else $error("result last flag disagrees with command state");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= ENT_CNT)
        else $error("used count beyond entries");

    a_oldest_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used != ENT_CNT) |-> (r_oldest == '0))
        else $error("replacement pointer moved before cache full");

    a_found_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found <= MAX_RES)
        else $error("too many write-backs in one flush");

    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (o_last && (o_request == REQ_NONE)))
        else $error("error result with request or not last");

endmodule

// ===== sv/scft_ram.sv =====
module scft_ram #(
    parameter int WIDTH = scft_pkg::TAG_W,
    parameter int DEPTH = scft_pkg::DEF_ENTRIES,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== dv/sector_cache_fifo_tags_check.sv =====
module sector_cache_fifo_tags_check #(
    parameter int ENTRIES = scft_pkg::DEF_ENTRIES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [scft_pkg::KIND_W-1:0]   i_kind,
    input  logic [scft_pkg::DRIVE_W-1:0]  i_drive,
    input  logic [scft_pkg::SECTOR_W-1:0] i_sector,
    input  logic                          i_cfg_valid,
    input  logic                          o_cfg_ready,
    input  logic [scft_pkg::SECTOR_W-1:0] i_cfg_data,
    input  logic                          o_valid,
    input  logic [scft_pkg::STATUS_W-1:0] o_status,
    input  logic [scft_pkg::SLOT_W-1:0]   o_slot,
    input  logic                          o_hit,
    input  logic [scft_pkg::REQ_W-1:0]    o_request,
    input  logic [scft_pkg::DRIVE_W-1:0]  o_req_drive,
    input  logic [scft_pkg::SECTOR_W-1:0] o_req_sector,
    input  logic                          o_last,
    output int                            o_fail_count,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import scft_pkg::*;

    logic [DRIVE_W-1:0]  tag_drive  [ENTRIES];
    logic [SECTOR_W-1:0] tag_sector [ENTRIES];
    logic [ENTRIES-1:0]  slot_valid;
    logic [ENTRIES-1:0]  slot_filled;
    logic [ENTRIES-1:0]  slot_dirty;
    int                  used_slots;
    int                  oldest;
    logic [SECTOR_W-1:0] sector_limit;

    t_result due_results [$];
    int      fails   = 0;
    int      waiting = 0;

    assign o_fail_count = fails;
    assign o_pending    = waiting;

    task automatic compare_field(input string name, input logic [SECTOR_W-1:0] want,
                                 input logic [SECTOR_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
            fails++;
        end
    endtask

    task automatic predict_cache_op(input logic [KIND_W-1:0] kind,
                                    input logic [DRIVE_W-1:0] drv,
                                    input logic [SECTOR_W-1:0] sec);
        t_result r;
        int      s;
        int      v;
        int      j;
        int      cnt;
        int      n;
        int      i;
        bit      held;
        s = -1;
        for (i = ENTRIES - 1; i >= 0; i--)
            if (slot_valid[i] && tag_drive[i] == drv && tag_sector[i] == sec)
                s = i;
        case (kind)
            K_FLUSHALL: begin
                held = 1'b0;
                n    = 0;
                cnt  = (used_slots > ENTRIES) ? ENTRIES : used_slots;
                for (i = 0; i < cnt && n < MAX_RESULTS; i++) begin
                    j = (oldest + i) % ENTRIES;
                    if (slot_valid[j] && slot_dirty[j]) begin
                        if (held)
                            due_results.push_back(r);
                        r = '{ST_OK, SLOT_W'(j), 1'b0, REQ_WBACK, tag_drive[j],
                              tag_sector[j], 1'b0};
                        held = 1'b1;
                        slot_dirty[j] = 1'b0;
                        n++;
                    end
                end
                if (!held)
                    r = '{ST_OK, '0, 1'b0, REQ_NONE, '0, '0, 1'b0};
                r.last = 1'b1;
                due_results.push_back(r);
            end
            K_OPEN: begin
                if (s >= 0) begin
                    due_results.push_back('{ST_OK, SLOT_W'(s), 1'b1, REQ_NONE, '0, '0, 1'b1});
                end else if (sec >= sector_limit) begin
                    due_results.push_back('{ST_RANGE, '0, 1'b0, REQ_NONE, '0, '0, 1'b1});
                end else begin
                    r = '{ST_OK, '0, 1'b0, REQ_NONE, '0, '0, 1'b1};
                    if (used_slots < ENTRIES) begin
                        v = used_slots;
                        used_slots++;
                    end else begin
                        v      = oldest;
                        oldest = (v + 1) % ENTRIES;
                        if (slot_valid[v] && slot_dirty[v]) begin
                            r.request    = REQ_WBACK;
                            r.req_drive  = tag_drive[v];
                            r.req_sector = tag_sector[v];
                        end
                    end
                    r.slot         = SLOT_W'(v);
                    tag_drive[v]   = drv;
                    tag_sector[v]  = sec;
                    slot_valid[v]  = 1'b1;
                    slot_filled[v] = 1'b0;
                    slot_dirty[v]  = 1'b0;
                    due_results.push_back(r);
                end
            end
            K_READ, K_WRITE, K_FLUSH1: begin
                if (s < 0) begin
                    due_results.push_back('{ST_NOT_CACHED, '0, 1'b0, REQ_NONE, '0, '0, 1'b1});
                end else begin
                    r = '{ST_OK, SLOT_W'(s), 1'b1, REQ_NONE, '0, '0, 1'b1};
                    if (kind == K_READ) begin
                        if (!slot_filled[s]) begin
                            slot_filled[s] = 1'b1;
                            r.hit          = 1'b0;
                            r.request      = REQ_FILL;
                            r.req_drive    = drv;
                            r.req_sector   = sec;
                        end
                    end else if (kind == K_WRITE) begin
                        slot_dirty[s]  = 1'b1;
                        slot_filled[s] = 1'b1;
                    end else if (slot_dirty[s]) begin
                        slot_dirty[s] = 1'b0;
                        r.request     = REQ_WBACK;
                        r.req_drive   = drv;
                        r.req_sector  = sec;
                    end
                    due_results.push_back(r);
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            slot_valid   = '0;
            slot_filled  = '0;
            slot_dirty   = '0;
            used_slots   = 0;
            oldest       = 0;
            sector_limit = '1;
            due_results.delete();
        end else begin
            if (o_valid === 1'b1) begin
                if (due_results.size() == 0) begin
                    $error("result with no transfer outstanding: slot 'h%0h status 'h%0h",
                           o_slot, o_status);
                    fails++;
                end else begin
                    want = due_results.pop_front();
                    compare_field("status", want.status, o_status);
                    compare_field("slot", want.slot, o_slot);
                    compare_field("hit", want.hit, o_hit);
                    compare_field("request", want.request, o_request);
                    compare_field("req_drive", want.req_drive, o_req_drive);
                    compare_field("req_sector", want.req_sector, o_req_sector);
                    compare_field("last", want.last, o_last);
                end
            end
            if (i_cfg_valid && o_cfg_ready)
                sector_limit = i_cfg_data;
            if (start && !busy)
                predict_cache_op(i_kind, i_drive, i_sector);
        end
        waiting = due_results.size();
    end

endmodule

// ===== dv/sector_cache_fifo_tags_test.sv =====
module sector_cache_fifo_tags_test;
    import scft_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int                ENTRIES     = DEF_ENTRIES;
    localparam int                SETTLE      = ENTRIES + 8;
    localparam int                CYCLE_LIMIT = 400000;
    localparam int                POOL_SIZE   = 24;
    localparam int                PHASE_ITEMS = 50;
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                start        = 1'b0;
    logic                busy;
    logic [KIND_W-1:0]   i_kind       = '0;
    logic [DRIVE_W-1:0]  i_drive      = '0;
    logic [SECTOR_W-1:0] i_sector     = '0;
    logic                i_cfg_valid  = 1'b0;
    logic                o_cfg_ready;
    logic [SECTOR_W-1:0] i_cfg_data   = '0;
    logic                o_valid;
    logic [STATUS_W-1:0] o_status;
    logic [SLOT_W-1:0]   o_slot;
    logic                o_hit;
    logic [REQ_W-1:0]    o_request;
    logic [DRIVE_W-1:0]  o_req_drive;
    logic [SECTOR_W-1:0] o_req_sector;
    logic                o_last;
    int                  fail_count;
    int                  pending;
    int                  cycle_count  = 0;

    logic [DRIVE_W-1:0]  pool_drive  [POOL_SIZE];
    logic [SECTOR_W-1:0] pool_sector [POOL_SIZE];
    logic [SECTOR_W-1:0] limits      [6];

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    sector_cache_fifo_tags #(.ENTRIES(ENTRIES)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_kind       (i_kind),
        .i_drive      (i_drive),
        .i_sector     (i_sector),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_slot       (o_slot),
        .o_hit        (o_hit),
        .o_request    (o_request),
        .o_req_drive  (o_req_drive),
        .o_req_sector (o_req_sector),
        .o_last       (o_last)
    );

    sector_cache_fifo_tags_check #(.ENTRIES(ENTRIES)) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_kind       (i_kind),
        .i_drive      (i_drive),
        .i_sector     (i_sector),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_slot       (o_slot),
        .o_hit        (o_hit),
        .o_request    (o_request),
        .o_req_drive  (o_req_drive),
        .o_req_sector (o_req_sector),
        .o_last       (o_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic issue_cmd(input logic [KIND_W-1:0] k, input logic [DRIVE_W-1:0] d,
                             input logic [SECTOR_W-1:0] s);
        @(negedge i_clk);
        start    <= 1'b1;
        i_kind   <= k;
        i_drive  <= d;
        i_sector <= s;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic idle_until_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [SECTOR_W-1:0] value);
        idle_until_drained();
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int n);
        int                  done;
        int                  burst;
        int                  b;
        int                  roll;
        int                  idx;
        int                  pause_at;
        logic [KIND_W-1:0]   k;
        logic [DRIVE_W-1:0]  d;
        logic [SECTOR_W-1:0] s;
        done     = 0;
        pause_at = $urandom_range(n / 4, (3 * n) / 4);
        while (done < n) begin
            burst = $urandom_range(1, 10);
            for (b = 0; b < burst && done < n; b++) begin
                roll = $urandom_range(0, 99);
                k = (roll < 35) ? K_OPEN :
                    (roll < 55) ? K_READ :
                    (roll < 75) ? K_WRITE :
                    (roll < 90) ? K_FLUSH1 : K_FLUSHALL;
                if ($urandom_range(0, 9) == 0) begin
                    d = DRIVE_W'($urandom_range(0, 254));
                    s = $urandom;
                end else begin
                    idx = $urandom_range(0, POOL_SIZE - 1);
                    d   = pool_drive[idx];
                    s   = pool_sector[idx];
                end
                issue_cmd(k, d, s);
                done++;
                if (done == pause_at)
                    idle_until_drained();
            end
            if ($urandom_range(0, 3) != 0) begin
                @(negedge i_clk);
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_drive[i]  = DRIVE_W'($urandom_range(0, 254));
            pool_sector[i] = (i % 2 == 1) ? $urandom : SECTOR_W'($urandom_range(0, 1999));
        end
        pool_drive[0]  = 8'd0;
        pool_sector[0] = 32'd0;
        pool_drive[1]  = 8'd254;
        pool_sector[1] = 32'hFFFF_FFFF;
        pool_drive[2]  = 8'd254;
        pool_sector[2] = 32'hFFFF_FFFE;
        pool_drive[3]  = 8'd1;
        pool_sector[3] = 32'd0;

        limits[0] = 32'hFFFF_FFFF;
        limits[1] = 32'd0;
        limits[2] = 32'd1000;
        limits[3] = $urandom;
        limits[4] = 32'h8000_0000;
        limits[5] = 32'd1;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty cache, misses, out-of-range, hits, fill, write-back, no-op kinds
        issue_cmd(K_FLUSHALL, 8'd0, 32'd0);
        issue_cmd(K_READ, 8'd0, 32'd0);
        issue_cmd(K_WRITE, 8'd0, 32'd0);
        issue_cmd(K_FLUSH1, 8'd0, 32'd0);
        issue_cmd(K_OPEN, 8'd0, 32'd0);
        issue_cmd(K_OPEN, 8'd254, 32'hFFFF_FFFF);
        issue_cmd(K_OPEN, 8'd254, 32'hFFFF_FFFE);
        issue_cmd(K_OPEN, 8'd0, 32'd0);
        issue_cmd(K_OPEN, 8'd1, 32'd0);
        issue_cmd(K_READ, 8'd0, 32'd0);
        issue_cmd(K_READ, 8'd0, 32'd0);
        issue_cmd(K_WRITE, 8'd0, 32'd0);
        issue_cmd(K_FLUSH1, 8'd0, 32'd0);
        issue_cmd(K_FLUSH1, 8'd0, 32'd0);
        issue_cmd(K_WRITE, 8'd254, 32'hFFFF_FFFE);
        issue_cmd(K_WRITE, 8'd1, 32'd0);
        issue_cmd(K_FLUSHALL, 8'd0, 32'd0);
        issue_cmd(K_FLUSHALL, 8'd0, 32'd0);
        issue_cmd(KIND_SPARE_LO, 8'd0, 32'd0);
        issue_cmd(KIND_SPARE_HI, 8'd254, 32'hFFFF_FFFF);
        issue_cmd(K_READ, 8'd254, 32'hFFFF_FFFE);

        foreach (limits[p]) begin
            write_limit(limits[p]);
            run_random(PHASE_ITEMS);
        end

        idle_until_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
